FILE: rtl/core/tdb_pkg.sv
// Shared constants, types and command/status structures for the text display buffer.
package tdb_pkg;

  localparam int MAX_COLUMNS = 32;
  localparam int MAX_ROWS    = 4;
  localparam int STORE_DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COL_W       = $clog2(MAX_COLUMNS + 1);
  localparam int ROW_W       = $clog2(MAX_ROWS + 1);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int CHAR_W      = 8;
  localparam int DIVD_W      = 9;
  localparam int DIVS_W      = 8;
  localparam int STEP_W      = $clog2(DIVD_W + 1);

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

  localparam logic [2:0] OP_WRITE  = 3'd0;
  localparam logic [2:0] OP_SETCUR = 3'd1;
  localparam logic [2:0] OP_CLEAR  = 3'd2;
  localparam logic [2:0] OP_HOME   = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  localparam logic [1:0] CFG_COLUMNS    = 2'd0;
  localparam logic [1:0] CFG_ROWS       = 2'd1;
  localparam logic [1:0] CFG_AUTOSCROLL = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WR_GO,
    S_WR_WAIT,
    S_WR_APPLY,
    S_RD_GO,
    S_RD_WAIT,
    S_RD_ISSUE,
    S_RD_CAPTURE,
    S_SC_GO1,
    S_SC_WAIT1,
    S_SC_GO2,
    S_SC_WAIT2,
    S_SC_APPLY,
    S_CLEAR,
    S_HOME,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    DIV_WS,
    DIV_COL,
    DIV_ROW
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     hold_col;
    logic     write_apply;
    logic     read_issue;
    logic     read_capture;
    logic     setcur_apply;
    logic     clear;
    logic     home;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic read_in_range;
  } status_t;

endpackage

FILE: rtl/core/text_display_buffer_autoscroll.sv
// Top level of the character display buffer with cursor, line wrap and autoscroll.
//
//  Channel   Signals                                   Transfer condition
//  command   start, busy, operation, char_code,        start high while busy low
//            column, row
//  result    done, cell_char, cursor_column,           done high (one cycle)
//            cursor_row, scrolling
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid and cfg_ready high
//
// Write, read and set cursor use a shared restoring divider: a set cursor runs two
// divisions, while a clear, home, out-of-range read or unused code runs none.
// Reset is synchronous and active high; the store reads as spaces after reset and
// after a clear, as the per-cell valid flags are all cleared at once.
// The receiver cannot stall; each result is shown for exactly one cycle.
module text_display_buffer_autoscroll (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] operation,
  input  logic [7:0] char_code,
  input  logic [7:0] column,
  input  logic [7:0] row,
  output logic       done,
  output logic [7:0] cell_char,
  output logic [4:0] cursor_column,
  output logic [1:0] cursor_row,
  output logic       scrolling,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_data
);
  import tdb_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  tdb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done)
  );

  tdb_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .char_code     (char_code),
    .column        (column),
    .row           (row),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cell_char     (cell_char),
    .cursor_column (cursor_column),
    .cursor_row    (cursor_row),
    .scrolling     (scrolling)
  );

endmodule

FILE: rtl/core/tdb_ram.sv
// Generic single-port-write, registered-read RAM.
module tdb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/tdb_div.sv
// Restoring divider producing one quotient bit per cycle.
module tdb_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tdb_pkg::DIVD_W-1:0] dividend,
  input  logic [tdb_pkg::DIVS_W-1:0] divisor,
  output logic                       done,
  output logic [tdb_pkg::DIVD_W-1:0] quotient,
  output logic [tdb_pkg::DIVS_W-1:0] remainder
);
  import tdb_pkg::*;

  logic              active;
  logic [STEP_W-1:0] steps;
  logic [DIVS_W-1:0] dsr;
  logic [DIVD_W-1:0] quo;
  logic [DIVS_W-1:0] rem;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;
  logic              take;

  assign trial = {rem, quo[DIVD_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign take  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      steps  <= '0;
    end else if (start) begin
      active <= 1'b1;
      steps  <= STEP_W'(DIVD_W);
    end else if (active) begin
      steps <= steps - STEP_W'(1);
      if (steps == STEP_W'(1)) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dsr <= divisor;
      quo <= dividend;
      rem <= '0;
    end else if (active) begin
      quo <= {quo[DIVD_W-2:0], take};
      rem <= take ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
    end
  end

  assign done      = active && (steps == STEP_W'(1));
  assign quotient  = quo;
  assign remainder = rem;

endmodule

FILE: rtl/core/tdb_ctrl.sv
// Controller state machine sequencing each operation of the display buffer.
module tdb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [2:0]       operation,
  input  tdb_pkg::status_t status,
  output tdb_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done
);
  import tdb_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (operation)
            OP_WRITE:  state_next = S_WR_GO;
            OP_SETCUR: state_next = S_SC_GO1;
            OP_CLEAR:  state_next = S_CLEAR;
            OP_HOME:   state_next = S_HOME;
            OP_READ:   state_next = S_RD_GO;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_WR_GO:      state_next = S_WR_WAIT;
      S_WR_WAIT:    if (status.div_done) state_next = S_WR_APPLY;
      S_WR_APPLY:   state_next = S_DONE;
      S_RD_GO:      state_next = status.read_in_range ? S_RD_WAIT : S_DONE;
      S_RD_WAIT:    if (status.div_done) state_next = S_RD_ISSUE;
      S_RD_ISSUE:   state_next = S_RD_CAPTURE;
      S_RD_CAPTURE: state_next = S_DONE;
      S_SC_GO1:     state_next = S_SC_WAIT1;
      S_SC_WAIT1:   if (status.div_done) state_next = S_SC_GO2;
      S_SC_GO2:     state_next = S_SC_WAIT2;
      S_SC_WAIT2:   if (status.div_done) state_next = S_SC_APPLY;
      S_SC_APPLY:   state_next = S_DONE;
      S_CLEAR:      state_next = S_DONE;
      S_HOME:       state_next = S_DONE;
      S_DONE:       state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_WR_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_WS;
      end
      S_WR_APPLY:   cmd.write_apply = 1'b1;
      S_RD_GO: begin
        cmd.div_start = status.read_in_range;
        cmd.div_sel   = DIV_WS;
      end
      S_RD_ISSUE:   cmd.read_issue = 1'b1;
      S_RD_CAPTURE: cmd.read_capture = 1'b1;
      S_SC_GO1: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_COL;
      end
      S_SC_GO2: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_ROW;
        cmd.hold_col  = 1'b1;
      end
      S_SC_APPLY:   cmd.setcur_apply = 1'b1;
      S_CLEAR:      cmd.clear = 1'b1;
      S_HOME:       cmd.home = 1'b1;
      S_DONE:       done = 1'b1;
      default:      cmd = '0;
    endcase
  end

endmodule

FILE: rtl/core/tdb_dpath.sv
// Datapath holding the cell store, cursor, window offset and configuration.
module tdb_dpath (
  input  logic                       clk,
  input  logic                       rst,
  input  tdb_pkg::cmd_t              cmd,
  output tdb_pkg::status_t           status,
  input  logic [7:0]                 char_code,
  input  logic [7:0]                 column,
  input  logic [7:0]                 row,
  input  logic                       cfg_valid,
  input  logic [1:0]                 cfg_index,
  input  logic [5:0]                 cfg_data,
  output logic [7:0]                 cell_char,
  output logic [4:0]                 cursor_column,
  output logic [1:0]                 cursor_row,
  output logic                       scrolling
);
  import tdb_pkg::*;

  logic [COL_W-1:0]       cfg_cols;
  logic [ROW_W-1:0]       cfg_rows;
  logic                   cfg_auto;
  logic [COL_W-1:0]       cols;
  logic [ROW_W-1:0]       rows;
  logic [CNT_W-1:0]       count;

  logic [ADDR_W-1:0]      ws;
  logic [4:0]             cur_col;
  logic [1:0]             cur_row;
  logic                   scroll_mode;
  logic [STORE_DEPTH-1:0] valid;
  logic [CHAR_W-1:0]      char_l;
  logic [7:0]             col_l;
  logic [7:0]             row_l;
  logic [4:0]             col_hold;
  logic [CHAR_W-1:0]      cell_reg;
  logic                   rd_valid;

  logic                   div_done;
  logic [DIVD_W-1:0]      div_dividend;
  logic [DIVS_W-1:0]      div_divisor;
  logic [DIVD_W-1:0]      div_quo;
  logic [DIVS_W-1:0]      div_rem;

  logic [ADDR_W-1:0]      wsm;
  logic [4:0]             cc;
  logic [1:0]             cr;
  logic [COL_W-1:0]       col_inc;
  logic [ROW_W-1:0]       row_inc;
  logic [CNT_W-1:0]       wsm_inc;
  logic [CNT_W-1:0]       logical_wr;
  logic [CNT_W-1:0]       logical_rd;
  logic [CNT_W-1:0]       sum_wr;
  logic [CNT_W-1:0]       sum_rd;
  logic [ADDR_W-1:0]      wr_cursor_addr;
  logic [ADDR_W-1:0]      waddr;
  logic [ADDR_W-1:0]      raddr;
  logic [CHAR_W-1:0]      rdata;

  always_comb begin
    if (cfg_cols == '0) begin
      cols = COL_W'(1);
    end else if (cfg_cols > COL_W'(MAX_COLUMNS)) begin
      cols = COL_W'(MAX_COLUMNS);
    end else begin
      cols = cfg_cols;
    end
    if (cfg_rows == '0) begin
      rows = ROW_W'(1);
    end else if (cfg_rows > ROW_W'(MAX_ROWS)) begin
      rows = ROW_W'(MAX_ROWS);
    end else begin
      rows = cfg_rows;
    end
  end

  assign count = CNT_W'({2'b00, cols} * {5'b00000, rows});

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_cols <= COL_W'(20);
      cfg_rows <= ROW_W'(4);
      cfg_auto <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_COLUMNS:    cfg_cols <= cfg_data;
        CFG_ROWS:       cfg_rows <= cfg_data[ROW_W-1:0];
        CFG_AUTOSCROLL: cfg_auto <= cfg_data[0];
        default:        cfg_auto <= cfg_auto;
      endcase
    end
  end

  always_comb begin
    case (cmd.div_sel)
      DIV_WS: begin
        div_dividend = {2'b00, ws};
        div_divisor  = count;
      end
      DIV_COL: begin
        div_dividend = {1'b0, col_l};
        div_divisor  = {2'b00, cols};
      end
      DIV_ROW: begin
        div_dividend = {1'b0, row_l} + {1'b0, div_quo[7:0]};
        div_divisor  = {5'b00000, rows};
      end
      default: begin
        div_dividend = '0;
        div_divisor  = DIVS_W'(1);
      end
    endcase
  end

  tdb_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign status.div_done      = div_done;
  assign status.read_in_range = (col_l < {2'b00, cols}) && (row_l < {5'b00000, rows});

  assign wsm = div_rem[ADDR_W-1:0];

  assign cc = ({1'b0, cur_col} >= cols) ? 5'd0 : cur_col;
  assign cr = ({1'b0, cur_row} >= rows) ? 2'd0 : cur_row;
  assign col_inc = {1'b0, cc} + COL_W'(1);
  assign row_inc = {1'b0, cr} + ROW_W'(1);
  assign wsm_inc = {1'b0, wsm} + CNT_W'(1);

  assign logical_wr = CNT_W'({6'b000000, cr} * {2'b00, cols}) + {3'b000, cc};
  assign logical_rd = CNT_W'({6'b000000, row_l[1:0]} * {2'b00, cols}) + {3'b000, col_l[4:0]};
  assign sum_wr = {1'b0, wsm} + logical_wr;
  assign sum_rd = {1'b0, wsm} + logical_rd;

  always_comb begin
    if (sum_wr >= count) begin
      wr_cursor_addr = ADDR_W'(sum_wr - count);
    end else begin
      wr_cursor_addr = sum_wr[ADDR_W-1:0];
    end
    if (sum_rd >= count) begin
      raddr = ADDR_W'(sum_rd - count);
    end else begin
      raddr = sum_rd[ADDR_W-1:0];
    end
  end

  assign waddr = scroll_mode ? wsm : wr_cursor_addr;

  tdb_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.write_apply),
    .waddr (waddr),
    .wdata (char_l),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ws          <= '0;
      cur_col     <= '0;
      cur_row     <= '0;
      scroll_mode <= 1'b0;
      valid       <= '0;
      cell_reg    <= '0;
    end else begin
      if (cmd.load) begin
        cell_reg <= '0;
      end
      if (cmd.write_apply) begin
        valid[waddr] <= 1'b1;
        if (scroll_mode) begin
          ws <= (wsm_inc == count) ? '0 : wsm_inc[ADDR_W-1:0];
        end else if (col_inc >= cols) begin
          cur_col <= '0;
          if (row_inc >= rows) begin
            cur_row     <= '0;
            scroll_mode <= cfg_auto;
          end else begin
            cur_row <= row_inc[1:0];
          end
        end else begin
          cur_col <= col_inc[4:0];
          cur_row <= cr;
        end
      end
      if (cmd.read_capture) begin
        cell_reg <= rd_valid ? rdata : SPACE_CHAR;
      end
      if (cmd.setcur_apply) begin
        cur_col     <= col_hold;
        cur_row     <= div_rem[1:0];
        scroll_mode <= 1'b0;
      end
      if (cmd.clear) begin
        valid       <= '0;
        ws          <= '0;
        cur_col     <= '0;
        cur_row     <= '0;
        scroll_mode <= 1'b0;
      end
      if (cmd.home) begin
        cur_col     <= '0;
        cur_row     <= '0;
        scroll_mode <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      char_l <= char_code;
      col_l  <= column;
      row_l  <= row;
    end
    if (cmd.hold_col) begin
      col_hold <= div_rem[4:0];
    end
    if (cmd.read_issue) begin
      rd_valid <= valid[raddr];
    end
  end

  assign cell_char     = cell_reg;
  assign cursor_column = cur_col;
  assign cursor_row    = cur_row;
  assign scrolling     = scroll_mode;

endmodule

FILE: bench/tb_text_display_buffer_autoscroll.sv
// Self-checking testbench for the text display buffer with cursor, line wrap and autoscroll.
`timescale 1ns / 1ps

module tb_text_display_buffer_autoscroll;
  import tdb_pkg::*;

  localparam logic [2:0] OP_SPARE_LO   = 3'd5;
  localparam logic [2:0] OP_SPARE_HI   = 3'd7;
  localparam int         SETTLE_CYCLES = 6;
  localparam int         TAIL_CYCLES   = 40;
  localparam int         CYCLE_LIMIT   = 250000;
  localparam int         PHASE_ITEMS   = 140;

  typedef struct packed {
    logic [7:0] glyph;
    logic [4:0] col_pos;
    logic [1:0] row_pos;
    logic       scroll;
  } display_status_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] operation = '0;
  logic [7:0] char_code = '0;
  logic [7:0] column = '0;
  logic [7:0] row = '0;
  logic       done;
  logic [7:0] cell_char;
  logic [4:0] cursor_column;
  logic [1:0] cursor_row;
  logic       scrolling;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [5:0] cfg_data = '0;

  // Shadow of the display state, updated at each accepted command.
  logic [7:0]  glyph_store [STORE_DEPTH];
  int unsigned window_base = 0;
  int unsigned cur_col = 0;
  int unsigned cur_row = 0;
  bit          scroll_on = 1'b0;
  int unsigned set_columns = 20;
  int unsigned set_rows = 4;
  bit          set_autoscroll = 1'b0;

  display_status_t pending_status [$];
  display_status_t oldest;
  int              errors = 0;
  int              cycle_count = 0;
  int              idle_pct = 17;

  text_display_buffer_autoscroll u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .char_code     (char_code),
    .column        (column),
    .row           (row),
    .done          (done),
    .cell_char     (cell_char),
    .cursor_column (cursor_column),
    .cursor_row    (cursor_row),
    .scrolling     (scrolling),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned active_columns();
    if (set_columns == 0) return 1;
    if (set_columns > MAX_COLUMNS) return MAX_COLUMNS;
    return set_columns;
  endfunction

  function automatic int unsigned active_rows();
    if (set_rows == 0) return 1;
    if (set_rows > MAX_ROWS) return MAX_ROWS;
    return set_rows;
  endfunction

  function automatic display_status_t apply_display_op(input logic [2:0] op,
                                                       input logic [7:0] ch,
                                                       input logic [7:0] col,
                                                       input logic [7:0] rw);
    int unsigned     cols;
    int unsigned     rows;
    int unsigned     count;
    int unsigned     base;
    display_status_t res;
    cols = active_columns();
    rows = active_rows();
    count = cols * rows;
    res.glyph = 8'h00;
    case (op)
      OP_WRITE: begin
        if (scroll_on) begin
          // In scroll mode the oldest cell is overwritten and the window moves on.
          base = window_base % count;
          glyph_store[base] = ch;
          window_base = (base + 1) % count;
        end else begin
          if (cur_col >= cols) cur_col = 0;
          if (cur_row >= rows) cur_row = 0;
          glyph_store[((window_base % count) + cur_row * cols + cur_col) % count] = ch;
          cur_col++;
          if (cur_col >= cols) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= rows) begin
              cur_row = 0;
              scroll_on = set_autoscroll;
            end
          end
        end
      end
      OP_SETCUR: begin
        cur_row = (rw % rows + col / cols) % rows;
        cur_col = col % cols;
        scroll_on = 1'b0;
      end
      OP_CLEAR, OP_HOME: begin
        if (op == OP_CLEAR) begin
          foreach (glyph_store[i]) glyph_store[i] = SPACE_CHAR;
          window_base = 0;
        end
        cur_col = 0;
        cur_row = 0;
        scroll_on = 1'b0;
      end
      OP_READ: begin
        if (col < cols && rw < rows)
          res.glyph = glyph_store[((window_base % count) + rw * cols + col) % count];
      end
      default: ;
    endcase
    res.col_pos = cur_col[4:0];
    res.row_pos = cur_row[1:0];
    res.scroll = scroll_on;
    return res;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer with start still high.
  task automatic issue_op(input logic [2:0] op, input logic [7:0] ch,
                          input logic [7:0] col, input logic [7:0] rw);
    bit lowered;
    lowered = 1'b0;
    while ($urandom_range(99) < idle_pct) begin
      if (!lowered) begin
        start <= 1'b0;
        lowered = 1'b1;
      end
      @(negedge clk);
    end
    start <= 1'b1;
    operation <= op;
    char_code <= ch;
    column <= col;
    row <= rw;
    do @(posedge clk); while (busy !== 1'b0);
    pending_status.push_back(apply_display_op(op, ch, col, rw));
    @(negedge clk);
  endtask

  task automatic drain_and_settle();
    start <= 1'b0;
    while (pending_status.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [5:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_COLUMNS:    set_columns = 32'(val);
      CFG_ROWS:       set_rows = 32'(val[2:0]);
      CFG_AUTOSCROLL: set_autoscroll = val[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_geometry(input logic [5:0] cols, input logic [5:0] rows,
                                input logic autoscroll);
    drain_and_settle();
    write_register(CFG_COLUMNS, cols);
    write_register(CFG_ROWS, rows);
    write_register(CFG_AUTOSCROLL, {5'd0, autoscroll});
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_and_cursor();
    issue_op(OP_READ, 8'h00, 8'd0, 8'd0);
    issue_op(OP_WRITE, 8'h00, 8'd0, 8'd0);
    issue_op(OP_WRITE, 8'hFF, 8'd0, 8'd0);
    issue_op(OP_READ, 8'h00, 8'd1, 8'd0);
    issue_op(OP_READ, 8'h00, 8'd20, 8'd0);
    issue_op(OP_READ, 8'h00, 8'd0, 8'd4);
    issue_op(OP_READ, 8'h00, 8'd255, 8'd255);
    issue_op(OP_SETCUR, 8'h00, 8'd255, 8'd255);
    issue_op(OP_SETCUR, 8'h00, 8'd19, 8'd3);
    issue_op(OP_WRITE, 8'h5A, 8'd0, 8'd0);
    issue_op(OP_READ, 8'h00, 8'd19, 8'd3);
    for (int op = int'(OP_SPARE_LO); op <= int'(OP_SPARE_HI); op++)
      issue_op(op[2:0], 8'hA5, 8'd7, 8'd2);
    issue_op(OP_HOME, 8'h00, 8'd0, 8'd0);
    issue_op(OP_CLEAR, 8'h00, 8'd0, 8'd0);
    issue_op(OP_READ, 8'h00, 8'd0, 8'd0);
  endtask

  task automatic test_autoscroll_wrap();
    apply_geometry(6'd2, 6'd1, 1'b1);
    issue_op(OP_WRITE, 8'h61, 8'd0, 8'd0);
    issue_op(OP_WRITE, 8'h62, 8'd0, 8'd0);
    issue_op(OP_WRITE, 8'h63, 8'd0, 8'd0);
    issue_op(OP_READ, 8'h00, 8'd0, 8'd0);
    issue_op(OP_READ, 8'h00, 8'd1, 8'd0);
    // Scroll mode survives autoscroll being switched off until the cursor is homed.
    apply_geometry(6'd2, 6'd1, 1'b0);
    issue_op(OP_WRITE, 8'h64, 8'd0, 8'd0);
    issue_op(OP_HOME, 8'h00, 8'd0, 8'd0);
    issue_op(OP_WRITE, 8'h65, 8'd0, 8'd0);
    apply_geometry(6'd0, 6'd0, 1'b1);
    issue_op(OP_WRITE, 8'hFF, 8'd0, 8'd0);
    issue_op(OP_READ, 8'h00, 8'd0, 8'd0);
    apply_geometry(6'd63, 6'd7, 1'b1);
    issue_op(OP_READ, 8'h00, 8'd31, 8'd3);
    issue_op(OP_WRITE, 8'h7E, 8'd0, 8'd0);
  endtask

  task automatic issue_random_op();
    int unsigned pick;
    logic [7:0]  col;
    logic [7:0]  rw;
    pick = $urandom_range(99);
    if ($urandom_range(3) != 0) begin
      col = 8'($urandom_range(active_columns() - 1));
      rw = 8'($urandom_range(active_rows() - 1));
    end else begin
      col = 8'($urandom_range(255));
      rw = 8'($urandom_range(255));
    end
    if (pick < 55 || pick >= 96)
      issue_op(OP_WRITE, 8'($urandom_range(255)), col, rw);
    else if (pick < 72)
      issue_op(OP_READ, 8'($urandom_range(255)), col, rw);
    else if (pick < 84)
      issue_op(OP_SETCUR, 8'($urandom_range(255)), col, rw);
    else if (pick < 90)
      issue_op(OP_HOME, 8'($urandom_range(255)), col, rw);
    else if (pick < 93)
      issue_op(OP_CLEAR, 8'($urandom_range(255)), col, rw);
    else
      issue_op(3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)), 8'($urandom_range(255)),
               col, rw);
  endtask

  task automatic test_random_traffic();
    logic [5:0] phase_cols [9] = '{6'd20, 6'd1, 6'd32, 6'd0, 6'd63, 6'd5, 6'd7, 6'd32, 6'd3};
    logic [5:0] phase_rows [9] = '{6'd4, 6'd1, 6'd4, 6'd0, 6'd7, 6'd3, 6'd2, 6'd1, 6'd4};
    bit         phase_auto [9] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
    for (int p = 0; p < 9; p++) begin
      apply_geometry(phase_cols[p], phase_rows[p], phase_auto[p]);
      idle_pct = (p < 3) ? 17 : (p < 6) ? 81 : 0;
      repeat (PHASE_ITEMS) issue_random_op();
    end
  endtask

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (pending_status.size() == 0) begin
        $display("%0t: result with none expected, got char %0h cursor %0d,%0d scroll %0b",
                 $time, cell_char, cursor_column, cursor_row, scrolling);
        errors++;
      end else begin
        oldest = pending_status.pop_front();
        check_field("cell_char", oldest.glyph, cell_char);
        check_field("cursor_column", {3'd0, oldest.col_pos}, {3'd0, cursor_column});
        check_field("cursor_row", {6'd0, oldest.row_pos}, {6'd0, cursor_row});
        check_field("scrolling", {7'd0, oldest.scroll}, {7'd0, scrolling});
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_status.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    foreach (glyph_store[i]) glyph_store[i] = SPACE_CHAR;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_and_cursor();
    test_autoscroll_wrap();
    test_random_traffic();
    drain_and_settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: text_display_buffer_autoscroll.f
rtl/core/tdb_pkg.sv
rtl/core/tdb_ram.sv
rtl/core/tdb_div.sv
rtl/core/tdb_ctrl.sv
rtl/core/tdb_dpath.sv
rtl/core/text_display_buffer_autoscroll.sv
bench/tb_text_display_buffer_autoscroll.sv
